@@ hdl/mmep_pkg.sv @@
// Package for the MatrixMarket coordinate edge parser.
// Holds the value width, character codes, parse phases and the result struct.
// Depends on nothing; every other file of the block imports it.
package mmep_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int OUT_WIDTH   = 32;

   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;

   localparam logic KIND_HEADER = 1'b0;
   localparam logic KIND_EDGE   = 1'b1;

   localparam logic [1:0] SLOT_FIRST  = 2'd0;
   localparam logic [1:0] SLOT_SECOND = 2'd1;
   localparam logic [1:0] SLOT_THIRD  = 2'd2;

   typedef logic [VALUE_WIDTH-1:0] value_type;
   typedef logic [OUT_WIDTH-1:0]   out_word_type;

   typedef enum logic [2:0] {
      PH_HDR_LS    = 3'd0,
      PH_HDR_CMT   = 3'd1,
      PH_HDR_SEEK  = 3'd2,
      PH_HDR_DIG   = 3'd3,
      PH_EDGE_SKIP = 3'd4,
      PH_EDGE_LS   = 3'd5,
      PH_EDGE_SEEK = 3'd6,
      PH_EDGE_DIG  = 3'd7
   } phase_type;

   typedef struct packed {
      logic         kind;
      out_word_type first_value;
      out_word_type second_value;
      out_word_type edge_index;
      logic         is_last;
   } result_type;

   // Handshake between the parser and the result register.
   typedef struct packed {
      logic load;
   } load_type;

   typedef struct packed {
      logic free;
   } slot_type;

endpackage

@@ hdl/mmep_parser.sv @@
// Input register and per-byte parse logic of the edge parser.
// One held byte is consumed per cycle when its result, if any, has a free slot.
// State updates and results are formed here. Depends on mmep_pkg.
module mmep_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_byte_req,
   input  logic                req_file_start,
   input  mmep_pkg::slot_type  slot,
   output mmep_pkg::load_type  load,
   output mmep_pkg::result_type result
);
   import mmep_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;

   phase_type  phase_ff, phase_in;
   logic [1:0] slot_ff, slot_in;
   value_type  acc_ff, acc_in;
   value_type  held_first_ff, held_first_in;
   value_type  held_second_ff, held_second_in;
   value_type  total_ff, total_in;
   value_type  count_ff, count_in;

   // Current state, with a file start clearing everything before the byte.
   phase_type  phase_c;
   logic [1:0] slot_c;
   value_type  acc_c, held_first_c, held_second_c, total_c, count_c;

   logic       is_digit, is_newline, done, emit_want, fire, accept;
   value_type  digit_val, acc_next_digit, count_plus, hdr_max;

   always_comb begin
      phase_c       = in_start_ff ? PH_HDR_LS : phase_ff;
      slot_c        = in_start_ff ? SLOT_FIRST : slot_ff;
      acc_c         = in_start_ff ? '0 : acc_ff;
      held_first_c  = in_start_ff ? '0 : held_first_ff;
      held_second_c = in_start_ff ? '0 : held_second_ff;
      total_c       = in_start_ff ? '0 : total_ff;
      count_c       = in_start_ff ? '0 : count_ff;

      is_digit   = (in_byte_ff >= CH_ZERO) && (in_byte_ff <= CH_NINE);
      is_newline = (in_byte_ff == CH_NEWLINE);
      digit_val  = is_digit ? VALUE_WIDTH'(in_byte_ff - CH_ZERO) : '0;
      acc_next_digit = (acc_c << 3) + (acc_c << 1) + digit_val;
      count_plus = count_c + VALUE_WIDTH'(1);
      hdr_max    = (held_first_c > held_second_c) ? held_first_c : held_second_c;
      done = (phase_c inside {PH_EDGE_SKIP, PH_EDGE_LS, PH_EDGE_SEEK, PH_EDGE_DIG})
             && (count_c == total_c);

      phase_in       = phase_c;
      slot_in        = slot_c;
      acc_in         = acc_c;
      held_first_in  = held_first_c;
      held_second_in = held_second_c;
      total_in       = total_c;
      count_in       = count_c;
      emit_want      = 1'b0;
      result         = '0;

      if (!done) begin
         case (phase_c)
            PH_HDR_LS, PH_EDGE_LS: begin
               if (in_byte_ff == CH_PERCENT) begin
                  phase_in = (phase_c == PH_HDR_LS) ? PH_HDR_CMT : PH_EDGE_SKIP;
               end else if (is_digit) begin
                  acc_in   = digit_val;
                  phase_in = (phase_c == PH_HDR_LS) ? PH_HDR_DIG : PH_EDGE_DIG;
               end else begin
                  phase_in = (phase_c == PH_HDR_LS) ? PH_HDR_SEEK : PH_EDGE_SEEK;
               end
            end
            PH_HDR_CMT: begin
               if (is_newline) phase_in = PH_HDR_LS;
            end
            PH_EDGE_SKIP: begin
               if (is_newline) phase_in = PH_EDGE_LS;
            end
            PH_HDR_SEEK, PH_EDGE_SEEK: begin
               if (is_digit) begin
                  acc_in   = digit_val;
                  phase_in = (phase_c == PH_HDR_SEEK) ? PH_HDR_DIG : PH_EDGE_DIG;
               end
            end
            PH_HDR_DIG: begin
               if (is_digit) begin
                  acc_in = acc_next_digit;
               end else if (slot_c == SLOT_FIRST) begin
                  held_first_in = acc_c;
                  slot_in       = SLOT_SECOND;
                  phase_in      = PH_HDR_SEEK;
               end else if (slot_c == SLOT_SECOND) begin
                  held_second_in = acc_c;
                  slot_in        = SLOT_THIRD;
                  phase_in       = PH_HDR_SEEK;
               end else begin
                  total_in  = acc_c;
                  count_in  = '0;
                  slot_in   = SLOT_FIRST;
                  phase_in  = is_newline ? PH_EDGE_LS : PH_EDGE_SKIP;
                  emit_want = 1'b1;
                  result.kind         = KIND_HEADER;
                  result.first_value  = OUT_WIDTH'(hdr_max);
                  result.second_value = OUT_WIDTH'(acc_c);
                  result.edge_index   = '0;
                  result.is_last      = (acc_c == '0);
               end
            end
            PH_EDGE_DIG: begin
               if (is_digit) begin
                  acc_in = acc_next_digit;
               end else if (slot_c == SLOT_FIRST) begin
                  held_first_in = acc_c;
                  slot_in       = SLOT_SECOND;
                  phase_in      = PH_EDGE_SEEK;
               end else begin
                  count_in  = count_plus;
                  slot_in   = SLOT_FIRST;
                  phase_in  = is_newline ? PH_EDGE_LS : PH_EDGE_SKIP;
                  emit_want = 1'b1;
                  result.kind         = KIND_EDGE;
                  result.first_value  = OUT_WIDTH'(held_first_c);
                  result.second_value = OUT_WIDTH'(acc_c);
                  result.edge_index   = OUT_WIDTH'(count_c);
                  result.is_last      = (count_plus == total_c);
               end
            end
            default: begin
               phase_in = PH_HDR_LS;
            end
         endcase
      end

      // A held byte moves on unless its result finds the result register full.
      fire        = in_valid_ff && (!emit_want || slot.free);
      load.load   = fire && emit_want;
      req_ready   = !in_valid_ff || fire;
      accept      = req_valid && req_ready;
      in_valid_in = accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         phase_ff       <= PH_HDR_LS;
         slot_ff        <= SLOT_FIRST;
         acc_ff         <= '0;
         held_first_ff  <= '0;
         held_second_ff <= '0;
         total_ff       <= '0;
         count_ff       <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (fire) begin
            phase_ff       <= phase_in;
            slot_ff        <= slot_in;
            acc_ff         <= acc_in;
            held_first_ff  <= held_first_in;
            held_second_ff <= held_second_in;
            total_ff       <= total_in;
            count_ff       <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff  <= req_byte_req;
         in_start_ff <= req_file_start;
      end
   end

   // The slot counter only ever names the first, second or third number.
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff != 2'd3)
      else $error("number slot out of range");

   // A header result leaves the block in an edge phase with a fresh counter.
   a_header_enters_edges: assert property (@(posedge clock) disable iff (reset)
      load.load && result.kind == KIND_HEADER |=>
         phase_ff[2] && count_ff == '0)
      else $error("header result did not start the edge section");

   // After the last edge, the counter has reached the entry total.
   a_last_edge_done: assert property (@(posedge clock) disable iff (reset)
      load.load && result.kind == KIND_EDGE && result.is_last |=>
         count_ff == total_ff)
      else $error("last edge did not finish the edge section");

   // Nothing is emitted once every entry has been delivered.
   a_quiet_when_done: assert property (@(posedge clock) disable iff (reset)
      done |-> !emit_want)
      else $error("result emitted after the last edge");

endmodule

@@ hdl/mmep_out_reg.sv @@
// Result register of the edge parser: holds one result until the consumer takes it.
// Depends on mmep_pkg.
module mmep_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  mmep_pkg::load_type    load,
   input  mmep_pkg::result_type  result,
   output mmep_pkg::slot_type    slot,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output mmep_pkg::result_type  rsp_result
);
   import mmep_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   always_comb begin
      slot.free = !valid_ff || rsp_ready;
      valid_in  = load.load ? 1'b1 : ((valid_ff && rsp_ready) ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load.load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = data_ff;

   // A new result is only loaded into a free or draining register.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load.load |-> (!valid_ff || rsp_ready))
      else $error("result register overwritten before transfer");

   // A load always shows a result in the next cycle.
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load.load |=> valid_ff)
      else $error("loaded result not presented");

   // Without a load, a taken result leaves the register empty.
   a_drain: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_ready && !load.load |=> !valid_ff)
      else $error("result presented twice");

endmodule

@@ hdl/matrix_market_edge_parser_core.sv @@
// Top level of the MatrixMarket coordinate edge parser.
// Depends on mmep_pkg, mmep_parser and mmep_out_reg.
//
// This block reads the text of a MatrixMarket coordinate file one byte per transfer
// and produces one header result followed by one edge result per entry line. The
// sustained rate is one byte per clock cycle: each byte first lands in an input
// register, then a short decode and a multiply-by-ten add update the parse state, and
// the result that a byte completes is held in the result register for the rsp_ side.
// A single result register separates the two sides, and the input keeps taking bytes
// while a result waits; only a byte that itself completes a header or edge stalls,
// and only while the result register is still full and rsp_ready is low, so req_ready
// depends on rsp_ready in that case. Set req_file_start on the first byte of each file
// to clear all parse state; once the last announced edge has been delivered, further
// bytes are taken and dropped.
module matrix_market_edge_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_req,
   input  logic        req_file_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [31:0] rsp_first_value,
   output logic [31:0] rsp_second_value,
   output logic [31:0] rsp_edge_index,
   output logic        rsp_is_last
);
   import mmep_pkg::*;

   slot_type   slot;
   load_type   load;
   result_type result;
   result_type rsp_result;

   mmep_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_byte_req   (req_byte_req),
      .req_file_start (req_file_start),
      .slot           (slot),
      .load           (load),
      .result         (result)
   );

   mmep_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .result     (result),
      .slot       (slot),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (rsp_result)
   );

   // The result struct is laid out with the port widths of the result channel.
   assign rsp_kind         = rsp_result.kind;
   assign rsp_first_value  = rsp_result.first_value;
   assign rsp_second_value = rsp_result.second_value;
   assign rsp_edge_index   = rsp_result.edge_index;
   assign rsp_is_last      = rsp_result.is_last;

endmodule
